[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk_s, rst_ns, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons)
`endif

`endif

[design/drs_pkg.sv]
// ----------------------------------------------------------------------------
// drs_pkg
// Types, constants and helper functions of the discovery RSSI scanner.
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int BUF_BYTES_DEF = 1024;
	localparam int WIN_LEN       = 76;
	localparam int MAC_OFF       = 59;
	localparam int MAC_LEN       = 12;
	localparam int RSSI_OFF      = 72;
	localparam int RSSI_CHARS    = 4;
	localparam int FIRST_POS     = 8;
	localparam int MAC_W         = 48;
	localparam int RSSI_W        = 15;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic REG_MAC_HIGH = 1'b0;
	localparam logic REG_MAC_LOW  = 1'b1;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_mark;
	} text_word_t;

	typedef struct packed {
		logic signed [RSSI_W-1:0] rssi_value;
		logic                     match_found;
	} result_word_t;

	typedef logic [MAC_LEN-1:0][7:0]    mac_chars_t;
	typedef logic [RSSI_CHARS-1:0][7:0] rssi_chars_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	// String compare over twelve characters; a shared zero ends it as a match.
	function automatic logic mac_match(input mac_chars_t txt, input mac_chars_t mac);
		logic ok;
		logic done;
		ok   = 1'b1;
		done = 1'b0;
		for (int j = 0; j < MAC_LEN; j++) begin
			if (!done) begin
				if (txt[j] != mac[j]) begin
					ok   = 1'b0;
					done = 1'b1;
				end else if (txt[j] == 8'h00) begin
					done = 1'b1;
				end
			end
		end
		return ok;
	endfunction

	// Whitespace, optional sign, then decimal digits.
	function automatic logic signed [RSSI_W-1:0] parse_rssi(input rssi_chars_t f);
		logic              in_digits;
		logic              done;
		logic              neg;
		logic [RSSI_W-2:0] v;
		logic [7:0]        c;
		in_digits = 1'b0;
		done      = 1'b0;
		neg       = 1'b0;
		v         = '0;
		for (int k = 0; k < RSSI_CHARS; k++) begin
			c = f[k];
			if (!done) begin
				if (!in_digits && is_space(c)) begin
					in_digits = 1'b0;
				end else if (!in_digits && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
					neg       = (c == CHAR_MINUS);
					in_digits = 1'b1;
				end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					v = (RSSI_W-1)'(v * (RSSI_W-1)'(10)) + (RSSI_W-1)'(c - CHAR_ZERO);
					in_digits = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
		end
		return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

[design/discovery_rssi_scanner.sv]
// ----------------------------------------------------------------------------
// discovery_rssi_scanner
// Scans a discovery response byte stream for the record of a configured MAC
// and returns its RSSI at the end of the capture.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | word
//  text      | in        | text_valid / text_ready   | text_word_t
//  result    | out       | result_valid/result_ready | result_word_t
//  cfg       | in        | cfg_we                    | cfg_index, cfg_data
//
//  One byte per cycle while the input is not stalled.
//  The window shift, candidate compare and number parse sit in one stage
//  after the input register; the result register follows.
//  At an end mark every record left in the window is tested at once.
//  The input stalls only while an end word waits on a full result register.
//  Reset clears the window, counters and configuration; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module discovery_rssi_scanner
	import drs_pkg::*;
#(
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_ready,
	input  text_word_t           text_word,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_word_t         result_word,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [MAC_W-1:0]     cfg_data
);

	localparam int MinPos = WIN_LEN + FIRST_POS;
	localparam int PosCap = (BUF_BYTES - 1 > MinPos) ? BUF_BYTES - 1 : MinPos;
	localparam int PosW   = $clog2(PosCap + 1);
	localparam int ExtLen = WIN_LEN + RSSI_OFF + RSSI_CHARS;

	logic [MAC_W-1:0]            mac_high_q;
	logic [MAC_W-1:0]            mac_low_q;
	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        end_s1;
	logic [WIN_LEN-1:0][7:0]     window_q;
	logic [PosW-1:0]             pos_q;
	logic                        ended_q;
	logic                        seen_q;
	logic signed [RSSI_W-1:0]    held_q;
	logic                        out_valid_q;
	result_word_t                out_q;

	logic                        stall;
	logic                        adv_s1;
	logic                        cut;
	logic [7:0]                  e_byte;
	logic [WIN_LEN-1:0][7:0]     win_nx;
	logic [ExtLen-1:0][7:0]      win_ext;
	logic [PosW-1:0]             pos_nx;
	mac_chars_t                  mac_chars;
	logic [WIN_LEN-1:0]          cand_hit;
	logic                        hit_any;
	logic signed [RSSI_W-1:0]    hit_rssi;
	mac_chars_t                  txt;
	rssi_chars_t                 fld;

	assign stall      = valid_s1 && end_s1 && out_valid_q && !result_ready;
	assign adv_s1     = valid_s1 && !stall;
	assign text_ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_high_q <= '0;
			mac_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAC_HIGH: mac_high_q <= cfg_data;
				REG_MAC_LOW:  mac_low_q  <= cfg_data;
				default:      mac_low_q  <= mac_low_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			end_s1   <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= text_valid;
			byte_s1  <= text_word.text_byte;
			end_s1   <= text_word.end_mark;
		end
	end

	always_comb begin
		cut     = (byte_s1 == 8'h00) || (pos_q >= PosW'(BUF_BYTES - 1));
		e_byte  = (ended_q || cut) ? 8'h00 : byte_s1;
		win_nx  = {e_byte, window_q[WIN_LEN-1:1]};
		win_ext = '0;
		win_ext[WIN_LEN-1:0] = win_nx;
		pos_nx  = (pos_q == PosW'(PosCap)) ? pos_q : pos_q + PosW'(1);
		for (int j = 0; j < MAC_LEN / 2; j++) begin
			mac_chars[j]               = mac_high_q[MAC_W-1-8*j -: 8];
			mac_chars[j + MAC_LEN / 2] = mac_low_q[MAC_W-1-8*j -: 8];
		end
	end

	// Test each window slot as a record start; bytes past the window read as zero.
	always_comb begin
		hit_any  = 1'b0;
		hit_rssi = '0;
		txt      = '0;
		fld      = '0;
		for (int k = WIN_LEN - 1; k >= 0; k--) begin
			for (int j = 0; j < MAC_LEN; j++) begin
				txt[j] = win_ext[k + MAC_OFF + j];
			end
			for (int j = 0; j < RSSI_CHARS; j++) begin
				fld[j] = win_ext[k + RSSI_OFF + j];
			end
			cand_hit[k] = !seen_q && (k == 0 || end_s1)
				&& (pos_nx >= PosW'(MinPos - k))
				&& (win_nx[k] == CHAR_PLUS) && mac_match(txt, mac_chars);
			if (cand_hit[k]) begin
				hit_any  = 1'b1;
				hit_rssi = parse_rssi(fld);
			end
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
			ended_q  <= 1'b0;
			seen_q   <= 1'b0;
			held_q   <= '0;
		end else if (adv_s1) begin
			if (end_s1) begin
				window_q <= '0;
				pos_q    <= '0;
				ended_q  <= 1'b0;
				seen_q   <= 1'b0;
				held_q   <= '0;
			end else begin
				window_q <= win_nx;
				pos_q    <= pos_nx;
				ended_q  <= ended_q || cut;
				if (cand_hit[0]) begin
					seen_q <= 1'b1;
					held_q <= hit_rssi;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1) begin
			out_q.match_found <= seen_q || hit_any;
			out_q.rssi_value  <= seen_q ? held_q : (hit_any ? hit_rssi : '0);
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

	`ASSERT_NEXT(a_end_gives_result, clk, arst_n, adv_s1 && end_s1, result_valid)
	`ASSERT_NEXT(a_end_clears_scan, clk, arst_n, adv_s1 && end_s1, pos_q == '0 && !seen_q)
	`ASSERT_IMPL(a_no_match_zero, clk, arst_n, result_valid && !result_word.match_found,
		result_word.rssi_value == '0)

endmodule

[tb/discovery_rssi_scanner_checker.sv]
// ----------------------------------------------------------------------------
// discovery_rssi_scanner_checker
// Watches the text, result and configuration ports of the scanner, keeps its
// own byte window and match state, predicts the RSSI word due at each end mark
// and compares every delivered result word against the oldest prediction.
// ----------------------------------------------------------------------------
module discovery_rssi_scanner_checker
	import drs_pkg::*;
#(
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	input  logic             text_ready,
	input  text_word_t       text_word,
	input  logic             result_valid,
	input  logic             result_ready,
	input  result_word_t     result_word,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [MAC_W-1:0] cfg_data,
	output int unsigned      fail_count,
	output int unsigned      results_owed
);

	localparam int unsigned POS_LIMIT = 32'h20000;

	logic [MAC_W-1:0] mac_high;
	logic [MAC_W-1:0] mac_low;
	logic [7:0]       window [WIN_LEN];
	int unsigned      text_pos;
	logic             text_done;
	logic             hit_seen;
	int               hit_rssi;
	result_word_t     rssi_due_q [$];
	int unsigned      mismatches;

	function automatic void clear_scan();
		for (int i = 0; i < WIN_LEN; i++) window[i] = 8'h00;
		text_pos  = 0;
		text_done = 1'b0;
		hit_seen  = 1'b0;
		hit_rssi  = 0;
	endfunction

	// Shift one byte in, then test the oldest slot as the start of a record.
	function automatic void advance_window(input logic [7:0] b);
		logic [2*MAC_W-1:0] mac_all;
		logic [7:0]         c;
		int                 k;
		int                 value;
		logic               neg;
		mac_all = {mac_high, mac_low};
		for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i + 1];
		window[WIN_LEN - 1] = b;
		if (text_pos < POS_LIMIT) text_pos++;
		if (hit_seen || text_pos < WIN_LEN + FIRST_POS || window[0] != CHAR_PLUS) return;
		for (int j = 0; j < MAC_LEN; j++) begin
			c = window[MAC_OFF + j];
			if (c != mac_all[2*MAC_W-1-8*j -: 8]) return;
			if (c == 8'h00) break;
		end
		hit_seen = 1'b1;
		k     = 0;
		value = 0;
		neg   = 1'b0;
		while (k < RSSI_CHARS) begin
			c = window[RSSI_OFF + k];
			if (c != CHAR_SPACE && (c < CHAR_TAB || c > CHAR_CR)) break;
			k++;
		end
		if (k < RSSI_CHARS) begin
			c = window[RSSI_OFF + k];
			if (c == CHAR_MINUS || c == CHAR_PLUS) begin
				neg = (c == CHAR_MINUS);
				k++;
			end
		end
		while (k < RSSI_CHARS) begin
			c = window[RSSI_OFF + k];
			if (c < CHAR_ZERO || c > CHAR_NINE) break;
			value = value * 10 + int'(c - CHAR_ZERO);
			k++;
		end
		hit_rssi = neg ? -value : value;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_word_t want;
		logic [7:0]   kept;
		if (!arst_n) begin
			mac_high = '0;
			mac_low  = '0;
			clear_scan();
			rssi_due_q.delete();
			mismatches = 0;
			fail_count   <= 0;
			results_owed <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (rssi_due_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result word: rssi %0d found %0b", $time,
							result_word.rssi_value, result_word.match_found);
					mismatches++;
				end else begin
					want = rssi_due_q.pop_front();
					if (result_word.rssi_value !== want.rssi_value
						|| result_word.match_found !== want.match_found) begin
						if (mismatches < 10)
							$display("%0t: result mismatch: rssi exp %0d got %0d, found exp %0b got %0b",
								$time, want.rssi_value, result_word.rssi_value,
								want.match_found, result_word.match_found);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_MAC_HIGH) mac_high = cfg_data;
				else mac_low = cfg_data;
			end
			if (text_valid && text_ready) begin
				kept = 8'h00;
				if (!text_done) begin
					if (text_word.text_byte == 8'h00 || text_pos >= BUF_BYTES - 1) text_done = 1'b1;
					else kept = text_word.text_byte;
				end
				advance_window(kept);
				if (text_word.end_mark) begin
					// flush so every record still in the window gets tested
					repeat (WIN_LEN) advance_window(8'h00);
					want.rssi_value  = hit_seen ? hit_rssi[RSSI_W-1:0] : '0;
					want.match_found = hit_seen;
					rssi_due_q.push_back(want);
					clear_scan();
				end
			end
			fail_count   <= mismatches;
			results_owed <= rssi_due_q.size();
		end
	end

endmodule

[tb/discovery_rssi_scanner_tb.sv]
// ----------------------------------------------------------------------------
// discovery_rssi_scanner_tb
// Feeds captured discovery responses to the scanner: directed captures for
// header handling, earliest match, RSSI parsing, short records, zero bytes,
// buffer capacity and MAC texts holding zeros, then random captures built
// from well-formed records, noise and broken text under several idle and
// stall patterns. A checker module predicts and compares the result words.
// ----------------------------------------------------------------------------
module discovery_rssi_scanner_tb;
	import drs_pkg::*;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             text_valid   = 1'b0;
	logic             text_ready;
	text_word_t       text_word    = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_word_t     result_word;
	logic             cfg_we       = 1'b0;
	logic             cfg_index    = REG_MAC_HIGH;
	logic [MAC_W-1:0] cfg_data     = '0;
	int unsigned      fail_count;
	int unsigned      results_owed;

	int                   send_idle     = 0;
	int                   recv_stall    = 0;
	logic [7:0]           capture_q [$];
	logic [2*MAC_W-1:0]   mac_now       = '0;
	int unsigned          words_sent    = 0;
	int unsigned          captures_sent = 0;
	string                hex_set       = "0123456789ABCDEF";
	string                odd_set       = " \t\n\r+-0123456789Ax";

	discovery_rssi_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_word    (text_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	discovery_rssi_scanner_checker rssi_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_word    (text_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall);
	end

	function automatic logic [7:0] hex_char();
		return hex_set[$urandom_range(15)];
	endfunction

	function automatic logic [7:0] digit_char();
		return 8'(CHAR_ZERO + $urandom_range(9));
	endfunction

	function automatic logic [2*MAC_W-1:0] random_mac();
		logic [2*MAC_W-1:0] m;
		for (int j = 0; j < MAC_LEN; j++) m[2*MAC_W-1-8*j -: 8] = hex_char();
		return m;
	endfunction

	function automatic logic [2*MAC_W-1:0] pick_mac();
		logic [2*MAC_W-1:0] m;
		int                 keep;
		m = random_mac();
		case ($urandom_range(5))
			0: m = '0;
			1: m = '1;
			2: begin
				keep = $urandom_range(MAC_LEN - 1);
				for (int j = keep; j < MAC_LEN; j++) m[2*MAC_W-1-8*j -: 8] = 8'h00;
			end
			default: ;
		endcase
		return m;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) capture_q.push_back(s[i]);
	endtask

	task automatic add_hex(input int n);
		repeat (n) capture_q.push_back(hex_char());
	endtask

	task automatic add_record(input logic [2*MAC_W-1:0] mac, input logic [31:0] rssi);
		add_text("+DISC:");
		add_hex(8);
		add_text(":");
		add_hex(32);
		add_text(":");
		add_hex(10);
		add_text(":");
		for (int j = 0; j < MAC_LEN; j++) capture_q.push_back(mac[2*MAC_W-1-8*j -: 8]);
		add_text(":");
		for (int k = 0; k < RSSI_CHARS; k++) capture_q.push_back(rssi[31-8*k -: 8]);
	endtask

	task automatic send_capture();
		for (int i = 0; i < capture_q.size(); i++) begin
			while ($urandom_range(99) < send_idle) begin
				text_valid <= 1'b0;
				@(posedge clk);
			end
			text_valid <= 1'b1;
			text_word  <= {capture_q[i], i == capture_q.size() - 1};
			do @(posedge clk); while (!text_ready);
			words_sent++;
		end
		captures_sent++;
		capture_q.delete();
	endtask

	task automatic settle_idle();
		text_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_mac(input logic [2*MAC_W-1:0] m);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAC_HIGH;
		cfg_data  <= m[2*MAC_W-1:MAC_W];
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAC_LOW;
		cfg_data  <= m[MAC_W-1:0];
		@(posedge clk);
		cfg_we  <= 1'b0;
		mac_now = m;
	endtask

	initial begin
		logic [31:0]        rssi_cases [5];
		int                 idle_pct [4];
		int                 stall_pct [4];
		logic [2*MAC_W-1:0] m;
		logic [31:0]        f;
		int                 n;
		int                 j;
		int                 kind;
		int unsigned        words_mark;
		int unsigned        caps_mark;

		rssi_cases = '{"9999", "-999", " \t-5", "AB12", {"-6", 8'h00, "7"}};
		idle_pct   = '{0, 49, 0, 15};
		stall_pct  = '{0, 0, 49, 15};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// MAC text still zero from reset
		add_text("A");
		send_capture();
		add_text("OK+DISIS+DISC:");
		send_capture();
		add_text("OK+DISI+");
		send_capture();
		add_text("OK+DISIS");
		capture_q.push_back(8'h00);
		add_record(mac_now, "-067");
		send_capture();

		load_mac("3C71BF12A0FE");
		add_text("OK+DISIS");
		add_record("3C71BF12A0FD", "-080");
		add_record(mac_now, "-067");
		add_text("OK+DISCE");
		send_capture();
		foreach (rssi_cases[i]) begin
			add_text("OK+DISIS");
			add_record(mac_now, rssi_cases[i]);
			send_capture();
		end
		add_text("OK+DISIS");
		add_record(mac_now, "-467");
		repeat (2) void'(capture_q.pop_back());
		send_capture();
		// last RSSI character falls on the first dropped byte
		add_text("OK+DISIS");
		add_hex(BUF_BYTES_DEF - WIN_LEN - 8);
		add_record(mac_now, "-067");
		add_text("OK+DISCE");
		send_capture();

		load_mac({"3C71BF12", 32'h0});
		add_text("OK+DISIS");
		add_record("3C71BF12A0FE", "-050");
		add_record("3C71BF12A0FE", "-051");
		repeat (9) void'(capture_q.pop_back());
		send_capture();

		load_mac('1);
		add_text("OK+DISIS");
		add_record('1, "1234");
		send_capture();

		for (int ph = 0; ph < 4; ph++) begin
			load_mac(pick_mac());
			send_idle  = idle_pct[ph];
			recv_stall = stall_pct[ph];
			words_mark = words_sent;
			caps_mark  = captures_sent;
			while (words_sent - words_mark < 60 || captures_sent - caps_mark < 3) begin
				kind = $urandom_range(99);
				if (kind < 15) begin
					n = $urandom_range(1, 40);
					repeat (n)
						capture_q.push_back(($urandom_range(7) == 0) ? 8'h00
							: 8'($urandom_range(1, 255)));
				end else begin
					if ($urandom_range(4) != 0) add_text("OK+DISIS");
					else add_hex($urandom_range(10));
					repeat ($urandom_range(2)) begin
						m = mac_now;
						case ($urandom_range(3))
							0, 1: ;
							2: begin
								j = $urandom_range(MAC_LEN - 1);
								m[2*MAC_W-1-8*j -: 8] = hex_char();
							end
							default: m = random_mac();
						endcase
						case ($urandom_range(3))
							0: f = {($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS),
								digit_char(), digit_char(), digit_char()};
							1: f = {CHAR_SPACE, CHAR_MINUS, digit_char(), digit_char()};
							2: begin
								for (int k = 0; k < RSSI_CHARS; k++)
									f[31-8*k -: 8] = ($urandom_range(9) == 0)
										? 8'(CHAR_TAB + $urandom_range(4))
										: odd_set[$urandom_range(odd_set.len() - 1)];
							end
							default: f = $urandom;
						endcase
						add_record(m, f);
					end
					if ($urandom_range(1)) add_text("OK+DISCE");
					if (capture_q.size() == 0) capture_q.push_back(hex_char());
					if (kind < 30) begin
						n = $urandom_range(1, capture_q.size());
						while (capture_q.size() > n) void'(capture_q.pop_back());
					end else if (kind < 40) begin
						capture_q[$urandom_range(capture_q.size() - 1)] = 8'h00;
					end else if (kind < 50) begin
						repeat ($urandom_range(1, 4))
							capture_q[$urandom_range(capture_q.size() - 1)] = CHAR_PLUS;
					end
				end
				send_capture();
				if ($urandom_range(7) == 0) load_mac(pick_mac());
			end
		end

		settle_idle();
		if (fail_count == 0) $display("discovery_rssi_scanner_tb: PASS");
		else $display("discovery_rssi_scanner_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("discovery_rssi_scanner_tb: FAIL");
		$finish;
	end

endmodule
